// File: hw/rtl/bfba_pkg.sv
// ----------------------------------------------------------------------------
// bfba_pkg: shared types and constants of the best-fit block allocator
// Request and response payloads, command and status codes, sequencer states.
// ----------------------------------------------------------------------------
package bfba_pkg;

  // Field widths
  localparam int unsigned KbW   = 11;
  localparam int unsigned AddrW = 10;

  // Largest managed memory and saturation point of the used count
  localparam logic [KbW-1:0] KbLimit = 11'd1024;
  localparam logic [KbW-1:0] UsedMax = 11'd2047;

  typedef enum logic [0:0] {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    STAT_BUMP    = 3'd0,
    STAT_POOL    = 3'd1,
    STAT_NOSPACE = 3'd2,
    STAT_FREED   = 3'd3,
    STAT_FULL    = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_SHIFT,
    S_RESP
  } state_e;

  typedef struct packed {
    cmd_e             command;
    logic [KbW-1:0]   size_kb;
    logic [AddrW-1:0] address;
  } req_t;

  typedef struct packed {
    status_e          status;
    logic [AddrW-1:0] block_address;
    logic [KbW-1:0]   used_kb;
  } resp_t;

  // One free-pool entry
  typedef struct packed {
    logic [KbW-1:0]   size;
    logic [AddrW-1:0] addr;
  } entry_t;

endpackage

// File: hw/rtl/best_fit_block_allocator_top.sv
// ----------------------------------------------------------------------------
// best_fit_block_allocator_top: kilobyte block allocator, bump plus best fit
// Allocates from a bump pointer while space remains, else takes the smallest
// fitting block from a free pool and closes the gap; frees append to the pool.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake                 payload
//  -------  ---------  ------------------------  -------------------------
//  in       input      in_valid_i / in_stall_o   req_t  (cmd, size, addr)
//  out      output     out_valid_o / out_stall_i resp_t (status, addr, used)
//  cfg      input      cfg_valid_i / cfg_ready_o total_kb, 11 bits
//
//  A free, a bump allocate or an early refusal passes through check and
//  response; a refusal after a full scan passes through check, scan, response.
//  A pool allocate passes through check, scan, shift and response: the pool
//  memory yields one entry a cycle for the best-fit scan and again for the
//  compaction that follows.
//  Reset clears the bump pointer, used count and pool count; no clearing pass.
//  A stalled result stays in the output register; the sequencer waits for it.
module best_fit_block_allocator_top
  import bfba_pkg::*;
#(
  parameter int unsigned POOL_DEPTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  req_t                 in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output resp_t                out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [KbW-1:0]       cfg_data_i
);

  localparam int unsigned IdxW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(POOL_DEPTH + 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(POOL_DEPTH);

  state_e state_q, state_d;

  logic [KbW-1:0]   total_kb_q, bump_q, bump_d, used_q, used_d;
  logic [CntW-1:0]  count_q, count_d;
  req_t             req_q, req_d;
  resp_t            res_q, res_d, out_q, out_d;
  logic             out_valid_q, out_valid_d;

  // scan / compaction sequencer
  logic [CntW-1:0]  idx_q, idx_d;
  logic [CntW-1:0]  rd_idx_q, rd_idx_d;
  logic             rd_vld_q, rd_vld_d;
  logic             found_q, found_d;
  logic [CntW-1:0]  best_idx_q, best_idx_d;
  logic [KbW-1:0]   best_size_q, best_size_d;
  logic [AddrW-1:0] best_addr_q, best_addr_d;

  // pool memory port
  entry_t           pool_mem [POOL_DEPTH];
  entry_t           rd_data_q;
  logic             rd_en;
  logic [IdxW-1:0]  rd_addr;
  logic             mem_we;
  logic [IdxW-1:0]  mem_waddr;
  entry_t           mem_wdata;

  // shared arithmetic
  logic [KbW-1:0]   limit;
  logic [KbW:0]     bump_sum;
  logic [KbW:0]     used_sum;
  logic [KbW-1:0]   used_inc;
  logic [KbW-1:0]   used_dec;

  assign limit    = (total_kb_q > KbLimit) ? KbLimit : total_kb_q;
  assign bump_sum = {1'b0, bump_q} + {1'b0, req_q.size_kb};
  assign used_sum = {1'b0, used_q} + {1'b0, req_q.size_kb};
  assign used_inc = used_sum[KbW] ? UsedMax : used_sum[KbW-1:0];
  assign used_dec = (req_q.size_kb > used_q) ? '0 : used_q - req_q.size_kb;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  // Sequence one request through check, scan, compaction and response
  always_comb begin
    state_d     = state_q;
    bump_d      = bump_q;
    used_d      = used_q;
    count_d     = count_q;
    req_d       = req_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    idx_d       = idx_q;
    rd_idx_d    = rd_idx_q;
    found_d     = found_q;
    best_idx_d  = best_idx_q;
    best_size_d = best_size_q;
    best_addr_d = best_addr_q;
    rd_en       = 1'b0;
    rd_addr     = idx_q[IdxW-1:0];
    mem_we      = 1'b0;
    mem_waddr   = count_q[IdxW-1:0];
    mem_wdata   = '{size: req_q.size_kb, addr: req_q.address};

    // retire the held result
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_data_i;
          state_d = S_CHECK;
        end
      end

      S_CHECK: begin
        res_d.block_address = '0;
        found_d             = 1'b0;
        idx_d               = '0;
        state_d             = S_RESP;
        if (req_q.command == CMD_FREE) begin
          if (count_q == DepthCnt) begin
            res_d.status = STAT_FULL;
          end else begin
            mem_we       = 1'b1;
            count_d      = count_q + CntW'(1);
            used_d       = used_dec;
            res_d.status = STAT_FREED;
          end
        end else if (req_q.size_kb == '0) begin
          res_d.status = STAT_NOSPACE;
        end else if (bump_sum <= {1'b0, limit}) begin
          res_d.block_address = bump_q[AddrW-1:0];
          bump_d              = bump_sum[KbW-1:0];
          used_d              = used_inc;
          res_d.status        = STAT_BUMP;
        end else if (count_q == '0) begin
          res_d.status = STAT_NOSPACE;
        end else begin
          state_d = S_SCAN;
        end
        res_d.used_kb = used_d;
      end

      S_SCAN: begin
        // issue the next read while comparing the previous entry
        rd_en = (idx_q < count_q);
        if (rd_en) begin
          idx_d    = idx_q + CntW'(1);
          rd_idx_d = idx_q;
        end
        if (rd_vld_q) begin
          if (rd_data_q.size >= req_q.size_kb &&
              (!found_q || rd_data_q.size < best_size_q)) begin
            found_d     = 1'b1;
            best_idx_d  = rd_idx_q;
            best_size_d = rd_data_q.size;
            best_addr_d = rd_data_q.addr;
          end
          if (rd_idx_q + CntW'(1) == count_q) begin
            if (found_d) begin
              idx_d   = best_idx_d + CntW'(1);
              state_d = S_SHIFT;
            end else begin
              res_d.status        = STAT_NOSPACE;
              res_d.block_address = '0;
              res_d.used_kb       = used_q;
              state_d             = S_RESP;
            end
          end
        end
      end

      S_SHIFT: begin
        // move each entry after the taken one down by one place
        rd_en = (idx_q < count_q);
        if (rd_en) begin
          idx_d    = idx_q + CntW'(1);
          rd_idx_d = idx_q;
        end
        if (rd_vld_q) begin
          mem_we    = 1'b1;
          mem_waddr = IdxW'(rd_idx_q - CntW'(1));
          mem_wdata = rd_data_q;
        end
        if (!rd_en && !rd_vld_q) begin
          count_d             = count_q - CntW'(1);
          used_d              = used_inc;
          res_d.status        = STAT_POOL;
          res_d.block_address = best_addr_q;
          res_d.used_kb       = used_inc;
          state_d             = S_RESP;
        end
      end

      S_RESP: begin
        // load the output register once it is free or draining
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    rd_vld_d = rd_en;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      total_kb_q  <= KbLimit;
      bump_q      <= '0;
      used_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      rd_vld_q    <= 1'b0;
      found_q     <= 1'b0;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      bump_q      <= bump_d;
      used_q      <= used_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      rd_vld_q    <= rd_vld_d;
      found_q     <= found_d;
      idx_q       <= idx_d;
      if (cfg_valid_i && cfg_ready_o) begin
        total_kb_q <= cfg_data_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    res_q       <= res_d;
    out_q       <= out_d;
    rd_idx_q    <= rd_idx_d;
    best_idx_q  <= best_idx_d;
    best_size_q <= best_size_d;
    best_addr_q <= best_addr_d;
  end

  // Pool memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pool_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_q <= pool_mem[rd_addr];
    end
  end

`ifndef ASSERT_OFF
  // The pool never holds more entries than it has places
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= DepthCnt)
    else $error("pool count above depth");

  // The bump pointer never passes the largest managed memory
  assert property (@(posedge clk_i) disable iff (!rst_ni) bump_q <= KbLimit)
    else $error("bump pointer above limit");

  // Every entry read back during the scan lies inside the pool
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && rd_vld_q) |-> rd_idx_q < count_q)
    else $error("scan read beyond pool count");

  // A pool allocation removes exactly one entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT && state_d == S_RESP) |=> count_q == $past(count_q) - CntW'(1))
    else $error("pool count not lowered on pool allocation");
`endif

endmodule
